>>> rtl/oven_profile_bang_bang_controller_unit_defines.svh
// Assertion macros used by the checker of the oven profile controller.
`ifndef OVEN_PROFILE_BANG_BANG_CONTROLLER_UNIT_DEFINES_SVH
`define OVEN_PROFILE_BANG_BANG_CONTROLLER_UNIT_DEFINES_SVH

// Checks that the condition on the right holds in the same cycle as the one on the left.
`define OPBBC_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("opbbc assertion failed");

// Checks that the condition on the right holds in the cycle after the one on the left.
`define OPBBC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("opbbc assertion failed");

`endif

>>> rtl/opbbc_pkg.sv
// Types and constants of the oven profile controller.
`timescale 1ns / 1ps

package opbbc_pkg;

  localparam int unsigned TGT_W    = 10;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned TEMP_W   = 11;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STEP_W   = 2;
  localparam int unsigned NUM_REGS = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 24;

  // Result field positions in m_tdata.
  localparam int unsigned M_STATUS_LSB = 0;
  localparam int unsigned M_HEATER_BIT = 2;
  localparam int unsigned M_STEP_LSB   = 3;
  localparam int unsigned M_TIME_LSB   = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_OFF  = 2'd1,
    ST_ON   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP0_TARGET = 3'd0,
    REG_STEP0_HOLD   = 3'd1,
    REG_STEP1_TARGET = 3'd2,
    REG_STEP1_HOLD   = 3'd3,
    REG_STEP2_TARGET = 3'd4,
    REG_STEP2_HOLD   = 3'd5,
    REG_STEP3_TARGET = 3'd6,
    REG_STEP3_HOLD   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    status_t             run_status;
    logic                running;
    logic [STEP_W-1:0]   step_index;
    logic [HOLD_W-1:0]   hold_left;
    logic                counting;
  } ctl_state_t;

  localparam ctl_state_t IDLE_STATE = '{
    run_status: ST_IDLE,
    running:    1'b0,
    step_index: '0,
    hold_left:  '0,
    counting:   1'b0
  };

  localparam logic [TGT_W-1:0]  TGT0_RST  = 10'd100;
  localparam logic [HOLD_W-1:0] HOLD0_RST = 16'd30;
  localparam logic [TGT_W-1:0]  TGT1_RST  = 10'd210;
  localparam logic [HOLD_W-1:0] HOLD1_RST = 16'd5;
  localparam logic [TGT_W-1:0]  TGT2_RST  = 10'd0;
  localparam logic [HOLD_W-1:0] HOLD2_RST = 16'd1;
  localparam logic [TGT_W-1:0]  TGT3_RST  = 10'd0;
  localparam logic [HOLD_W-1:0] HOLD3_RST = 16'd1;

endpackage

>>> rtl/opbbc_step.sv
// Next-state logic of the controller for one request.
`timescale 1ns / 1ps

module opbbc_step
  import opbbc_pkg::*;
#(
  parameter int unsigned MAX_STEPS = 4
) (
  input  ctl_state_t                       cur,
  input  logic [KIND_W-1:0]                kind,
  input  logic signed [TEMP_W-1:0]         temperature,
  input  logic [NUM_REGS-1:0][TGT_W-1:0]   tgt,
  input  logic [NUM_REGS-1:0][HOLD_W-1:0]  hld,
  output ctl_state_t                       nxt
);

  localparam logic [STEP_W:0] MaxSteps = (STEP_W + 1)'(MAX_STEPS);

  logic [STEP_W:0]          next_idx;
  logic                     next_end;
  logic [HOLD_W-1:0]        hold_dec;
  logic [STEP_W-1:0]        tgt_idx;
  logic signed [TEMP_W-1:0] target_s;
  logic                     stay;

  assign next_idx = {1'b0, cur.step_index} + (STEP_W + 1)'(1);
  assign next_end = (next_idx >= MaxSteps) || (tgt[next_idx[STEP_W-1:0]] == '0);
  assign hold_dec = cur.hold_left - HOLD_W'(1);

  always_comb begin
    nxt      = cur;
    stay     = 1'b1;
    tgt_idx  = cur.step_index;
    target_s = '0;
    case (kind_t'(kind))
      KIND_TICK: begin
        if (cur.running) begin
          if (cur.counting) begin
            nxt.hold_left = hold_dec;
            if (hold_dec == '0) begin
              if (next_end) begin
                nxt  = IDLE_STATE;
                stay = 1'b0;
              end else begin
                tgt_idx       = next_idx[STEP_W-1:0];
                nxt.step_index = next_idx[STEP_W-1:0];
                nxt.hold_left  = hld[next_idx[STEP_W-1:0]];
                nxt.counting   = 1'b0;
              end
            end
          end
          target_s = $signed({1'b0, tgt[tgt_idx]});
          if (stay) begin
            if ((temperature >= target_s) && (cur.run_status == ST_ON)) begin
              nxt.counting   = 1'b1;
              nxt.run_status = ST_OFF;
            end else if ((temperature < target_s) && (cur.run_status == ST_OFF)) begin
              nxt.run_status = ST_ON;
            end
          end
        end
      end
      KIND_START: begin
        if (tgt[0] == '0) begin
          nxt = IDLE_STATE;
        end else begin
          nxt.run_status = ST_OFF;
          nxt.running    = 1'b1;
          nxt.step_index = '0;
          nxt.hold_left  = hld[0];
          nxt.counting   = 1'b0;
        end
      end
      KIND_STOP: begin
        nxt = IDLE_STATE;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/oven_profile_bang_bang_controller_unit.sv
// Top level of the oven profile on/off temperature controller.
//
//   channel  signals                          payload
//   s        s_tvalid s_tready s_tdata s_tuser  tuser kind, tdata temperature
//   m        m_tvalid m_tready m_tdata          status, heater, step, time left
//   cfg      cfg_valid cfg_ready cfg_index      cfg_data, always ready
//
// Each request passes through the input register and then the result register.
// A new request is taken every cycle while m_tready is high; the rate is set by the combinational step logic.
// Reset clears the controller to idle and loads the default profile.
// A stalled result holds the result register and, once the input register is full,
// deasserts s_tready.
`timescale 1ns / 1ps

module oven_profile_bang_bang_controller_unit
  import opbbc_pkg::*;
#(
  parameter int unsigned MAX_STEPS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_DATA_W-1:0]    s_tdata,   // [10:0] temperature, rest zero
  input  logic [KIND_W-1:0]      s_tuser,   // [1:0] kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_W-1:0]    m_tdata,   // [1:0] status, [2] heater_on,
                                            // [4:3] step_number, [20:5] time_left
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [NUM_REGS-1:0][TGT_W-1:0]  tgt;
  logic [NUM_REGS-1:0][HOLD_W-1:0] hld;

  ctl_state_t               state;
  ctl_state_t               state_next;
  logic                     in_valid;
  logic [KIND_W-1:0]        in_kind;
  logic signed [TEMP_W-1:0] in_temp;
  logic                     out_valid;
  logic [M_DATA_W-1:0]      out_data;
  logic                     advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt[0] <= TGT0_RST;
      hld[0] <= HOLD0_RST;
      tgt[1] <= TGT1_RST;
      hld[1] <= HOLD1_RST;
      tgt[2] <= TGT2_RST;
      hld[2] <= HOLD2_RST;
      tgt[3] <= TGT3_RST;
      hld[3] <= HOLD3_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP0_TARGET: tgt[0] <= cfg_data[TGT_W-1:0];
        REG_STEP0_HOLD:   hld[0] <= cfg_data[HOLD_W-1:0];
        REG_STEP1_TARGET: tgt[1] <= cfg_data[TGT_W-1:0];
        REG_STEP1_HOLD:   hld[1] <= cfg_data[HOLD_W-1:0];
        REG_STEP2_TARGET: tgt[2] <= cfg_data[TGT_W-1:0];
        REG_STEP2_HOLD:   hld[2] <= cfg_data[HOLD_W-1:0];
        REG_STEP3_TARGET: tgt[3] <= cfg_data[TGT_W-1:0];
        REG_STEP3_HOLD:   hld[3] <= cfg_data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_temp <= $signed(s_tdata[TEMP_W-1:0]);
    end
  end

  opbbc_step #(
    .MAX_STEPS (MAX_STEPS)
  ) u_step (
    .cur         (state),
    .kind        (in_kind),
    .temperature (in_temp),
    .tgt         (tgt),
    .hld         (hld),
    .nxt         (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE_STATE;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {3'b000, state_next.hold_left, state_next.step_index,
                   state_next.run_status == ST_ON, state_next.run_status};
    end
  end

endmodule

>>> rtl/opbbc_checker.sv
// Port-level checker of the oven profile controller and its binding.
`timescale 1ns / 1ps
`include "oven_profile_bang_bang_controller_unit_defines.svh"

module opbbc_checker
  import opbbc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  logic [1:0]        chk_status;
  logic              chk_heater;
  logic [STEP_W-1:0] chk_step;
  logic [HOLD_W-1:0] chk_time;
  logic              chk_idle_zero;

  assign chk_status    = m_tdata[M_STATUS_LSB +: 2];
  assign chk_heater    = m_tdata[M_HEATER_BIT];
  assign chk_step      = m_tdata[M_STEP_LSB +: STEP_W];
  assign chk_time      = m_tdata[M_TIME_LSB +: HOLD_W];
  assign chk_idle_zero = (chk_step == '0) && (chk_time == '0);

  `OPBBC_ASSERT_SAME(a_heater_matches_status, m_tvalid, chk_heater == (chk_status == ST_ON))
  `OPBBC_ASSERT_SAME(a_idle_clears_step, m_tvalid && (chk_status == ST_IDLE), chk_idle_zero)
  `OPBBC_ASSERT_NEXT(a_stalled_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind oven_profile_bang_bang_controller_unit opbbc_checker u_opbbc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> test/tb.sv
// Self-checking testbench of the oven profile controller, driven by directed and random requests.
`timescale 1ns / 1ps

module tb;
  import opbbc_pkg::*;

  localparam int STEP_COUNT = 4;
  localparam int PIPE_CYCLES = 2;
  localparam int TEMP_MIN = -256;
  localparam int TEMP_MAX = 1023;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_PROFILES = 12;
  localparam int REQS_PER_PROFILE = 110;
  localparam int LONG_STALL_AT = 500;
  localparam int LONG_STALL_CYCLES = 300;

  typedef struct {
    status_t           status;
    logic              heater;
    logic [STEP_W-1:0] step;
    logic [HOLD_W-1:0] time_left;
  } reading_t;

  class oven_scoreboard;
    logic [TGT_W-1:0]  target[STEP_COUNT];
    logic [HOLD_W-1:0] hold[STEP_COUNT];
    status_t           run_status;
    logic              running;
    logic [STEP_W-1:0] step_index;
    logic [HOLD_W-1:0] hold_left;
    logic              counting;
    reading_t          pending[$];
    int requests;
    int results;
    int mismatches;
    int step_changes;
    int programs_done;
    int reg_writes;

    function new();
      target = '{TGT0_RST, TGT1_RST, TGT2_RST, TGT3_RST};
      hold = '{HOLD0_RST, HOLD1_RST, HOLD2_RST, HOLD3_RST};
      go_idle();
    endfunction

    function void go_idle();
      run_status = ST_IDLE;
      running = 1'b0;
      step_index = '0;
      hold_left = '0;
      counting = 1'b0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      reg_writes++;
      if (idx[0])
        hold[idx >> 1] = value[HOLD_W-1:0];
      else
        target[idx >> 1] = value[TGT_W-1:0];
    endfunction

    function int current_goal();
      return running ? int'(target[step_index]) : int'(TGT0_RST);
    endfunction

    function void begin_program();
      if (target[0] == '0) begin
        go_idle();
        return;
      end
      running = 1'b1;
      step_index = '0;
      hold_left = hold[0];
      counting = 1'b0;
      run_status = ST_OFF;
    endfunction

    function void take_tick(logic signed [TEMP_W-1:0] temp);
      int next;
      int goal;
      if (!running)
        return;
      if (counting) begin
        hold_left = hold_left - HOLD_W'(1);
        if (hold_left == '0) begin
          next = int'(step_index) + 1;
          if (next >= STEP_COUNT || target[next] == '0) begin
            go_idle();
            programs_done++;
            return;
          end
          step_index = next[STEP_W-1:0];
          hold_left = hold[step_index];
          counting = 1'b0;
          step_changes++;
        end
      end
      goal = int'(target[step_index]);
      if (int'(temp) >= goal && run_status == ST_ON) begin
        counting = 1'b1;
        run_status = ST_OFF;
      end else if (int'(temp) < goal && run_status == ST_OFF) begin
        run_status = ST_ON;
      end
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic signed [TEMP_W-1:0] temp);
      reading_t r;
      requests++;
      case (kind)
        KIND_TICK:  take_tick(temp);
        KIND_START: begin_program();
        KIND_STOP:  go_idle();
        default: ;
      endcase
      r.status = run_status;
      r.heater = (run_status == ST_ON);
      r.step = step_index;
      r.time_left = hold_left;
      pending.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      $display("tb: error at result %0d: %s", results, what);
    endtask

    task check_result(logic [M_DATA_W-1:0] data);
      reading_t want;
      logic [1:0] got_status;
      logic [STEP_W-1:0] got_step;
      logic [HOLD_W-1:0] got_time;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      want = pending.pop_front();
      got_status = data[M_STATUS_LSB +: 2];
      got_step = data[M_STEP_LSB +: STEP_W];
      got_time = data[M_TIME_LSB +: HOLD_W];
      if (got_status !== want.status)
        report($sformatf("status %0d, expected %0d", got_status, want.status));
      if (data[M_HEATER_BIT] !== want.heater)
        report($sformatf("heater %b, expected %b", data[M_HEATER_BIT], want.heater));
      if (got_step !== want.step)
        report($sformatf("step %0d, expected %0d", got_step, want.step));
      if (got_time !== want.time_left)
        report($sformatf("time left %0d, expected %0d", got_time, want.time_left));
    endtask

    task close_out();
      if (pending.size() != 0)
        report($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [KIND_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  oven_scoreboard sb;
  logic sender_calm;
  int profiles;

  oven_profile_bang_bang_controller_unit #(
    .MAX_STEPS(STEP_COUNT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic send_req(logic [KIND_W-1:0] kind, int temp);
    int gap;
    logic [TEMP_W-1:0] raw;
    if ($urandom_range(0, 29) == 0)
      sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 16);
    raw = temp[TEMP_W-1:0];
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(S_DATA_W-TEMP_W){1'b0}}, raw};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(kind, raw);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending.size() != 0)
      sb.report("results stopped arriving");
    repeat (PIPE_CYCLES + 3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_profile(logic [CFG_DATA_W-1:0] values[8]);
    profiles++;
    for (int i = 0; i < 8; i++)
      write_reg(reg_idx_t'(i), values[i]);
  endtask

  task automatic random_profile(int flavor);
    logic [CFG_DATA_W-1:0] values[8];
    for (int s = 0; s < STEP_COUNT; s++) begin
      case (flavor)
        1: begin
          values[2*s] = 16'd1023;
          values[2*s+1] = 16'd65535;
        end
        2: begin
          values[2*s] = 16'd1;
          values[2*s+1] = 16'd1;
        end
        default: begin
          if ($urandom_range(0, s == 0 ? 14 : 5) == 0)
            values[2*s] = '0;
          else
            values[2*s] = 16'($urandom_range(1, 1023));
          if ($urandom_range(0, 19) == 0)
            values[2*s+1] = 16'($urandom_range(1, 65535));
          else
            values[2*s+1] = 16'($urandom_range(1, 6));
        end
      endcase
    end
    write_profile(values);
  endtask

  task automatic random_req();
    int r;
    int goal;
    int temp;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 99);
    if (!sb.running)
      kind = (r < 55) ? KIND_START : (r < 75) ? KIND_TICK : (r < 88) ? KIND_STOP : KIND_UNUSED;
    else
      kind = (r < 3) ? KIND_START : (r < 6) ? KIND_STOP : (r < 8) ? KIND_UNUSED : KIND_TICK;
    goal = sb.current_goal();
    r = $urandom_range(0, 99);
    if (r < 20)
      temp = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
    else if (r < 55)
      temp = goal - int'($urandom_range(1, 40));
    else if (r < 90)
      temp = goal + int'($urandom_range(0, 40));
    else
      temp = goal - 1 + int'($urandom_range(0, 1));
    if (temp < TEMP_MIN)
      temp = TEMP_MIN;
    if (temp > TEMP_MAX)
      temp = TEMP_MAX;
    send_req(kind, temp);
  endtask

  initial begin
    int gap;
    logic calm;
    calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0)
        calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (sb.results == LONG_STALL_AT)
        gap = LONG_STALL_CYCLES;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    sb = new();
    sender_calm = 1'b0;
    profiles = 0;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_TICK;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_STEP0_TARGET;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default profile after reset: tick, stop and unused kind while idle, then a short run.
    send_req(KIND_TICK, TEMP_MIN);
    send_req(KIND_STOP, 0);
    send_req(KIND_UNUSED, TEMP_MAX);
    send_req(KIND_START, 0);
    send_req(KIND_TICK, 20);
    settle();

    // Walk all four steps and run past the last one.
    write_profile('{16'd100, 16'd2, 16'd1023, 16'd1, 16'd1, 16'd3, 16'd5, 16'd1});
    send_req(KIND_START, 0);
    send_req(KIND_TICK, TEMP_MAX);
    send_req(KIND_TICK, TEMP_MIN);
    send_req(KIND_TICK, 100);
    send_req(KIND_UNUSED, 0);
    send_req(KIND_TICK, 0);
    send_req(KIND_TICK, 50);
    send_req(KIND_TICK, 1023);
    send_req(KIND_TICK, 1023);
    send_req(KIND_TICK, -1);
    send_req(KIND_TICK, 1);
    send_req(KIND_TICK, 0);
    send_req(KIND_TICK, 7);
    send_req(KIND_TICK, 3);
    send_req(KIND_TICK, 5);
    send_req(KIND_TICK, 0);
    send_req(KIND_START, 0);
    send_req(KIND_TICK, 0);
    send_req(KIND_START, 0);
    send_req(KIND_STOP, 0);
    settle();

    // Empty program, then a zero hold that wraps on its first countdown tick.
    write_profile('{16'd0, 16'd3, 16'd200, 16'd2, 16'd0, 16'd1, 16'd0, 16'd1});
    send_req(KIND_START, 0);
    send_req(KIND_TICK, 0);
    settle();
    write_profile('{16'd500, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd1});
    send_req(KIND_START, 0);
    send_req(KIND_TICK, 0);
    send_req(KIND_TICK, 600);
    send_req(KIND_TICK, 600);
    send_req(KIND_STOP, 0);
    settle();

    for (int p = 0; p < RANDOM_PROFILES; p++) begin
      random_profile(p);
      for (int i = 0; i < REQS_PER_PROFILE; i++)
        random_req();
      settle();
    end

    sb.close_out();
    $display("tb: %0d requests over %0d profiles, %0d results checked, %0d register writes",
             sb.requests, profiles, sb.results, sb.reg_writes);
    $display("tb: %0d step changes and %0d programs run to completion",
             sb.step_changes, sb.programs_done);
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
